@@ rtl/ssms_pkg.sv @@
// shared types and constants for the subset-sum minimum split time block
// no dependencies; every other rtl file but ssms_ram imports this package
`default_nettype none

package ssms_pkg;

  localparam int WORD_W      = 64;
  localparam int WORD_SH     = 6;
  localparam int COST_W      = 16;
  localparam int RATE_W      = 16;
  localparam int TIME_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register indexes, selected by paddr[2]
  localparam logic REG_WATER = 1'b0;
  localparam logic REG_FIRE  = 1'b1;

  // one classified item on its way from the front to the back
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              last;
    logic              shift_en;
  } task_t;

  // back status seen by the front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

@@ rtl/ssms_if.sv @@
// valid/ready channel interfaces for items and results
// depends on ssms_pkg
`default_nettype none

interface ssms_item_if;
  import ssms_pkg::*;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] item_cost;
  logic              item_last;
  modport source (output valid, output item_cost, output item_last, input ready);
  modport sink   (input valid, input item_cost, input item_last, output ready);
endinterface

interface ssms_result_if;
  import ssms_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] min_time;
  logic              overflow;
  modport source (output valid, output min_time, output overflow, input ready);
  modport sink   (input valid, input min_time, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/subset_sum_min_split_time.sv @@
// top level of the subset-sum minimum split time block: apb registers and wiring
// depends on ssms_pkg, ssms_if, ssms_front, ssms_queue and ssms_back
`default_nettype none

// item costs come in as beats; each nonzero cost within MAX_TOTAL runs a
// shift-or over the reachability bitset held in a 64-bit-word ram, walking
// from the top word down to word cost/64 through the states S_SH_RD0,
// S_SH_RD1 and S_SH_WR for each word (one read-modify-write of the
// destination plus two source words). on the beat marked last the back
// divides the total by the water rate (one bit a cycle), scans every split
// in the states S_SC_RD and S_SC_EV, emits one result and sweeps all
// MAX_TOTAL/64 + 1 words of the bitset clear. the same clearing sweep runs
// after reset, during which no item is taken; register writes are taken at
// any time but belong to idle periods.
// a two-entry queue and a front stage let new beats in while the back works
// and a result register holds the answer until the sink takes it.
// registers: water_rate at byte 0, fire_rate at byte 4, a zero rate acts as one

module subset_sum_min_split_time
  import ssms_pkg::*;
#(
  parameter int MAX_TOTAL = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  ssms_item_if.sink              items,
  ssms_result_if.source          results
);

  logic [RATE_W-1:0] water_rate;
  logic [RATE_W-1:0] fire_rate;

  logic       q_push;
  task_t      q_wdata;
  logic       q_full;
  logic       q_pop;
  task_t      q_rdata;
  logic       q_empty;
  back_stat_t stat;

  // register file, word aligned, low address bits ignored
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIRE) ? APB_DW'(fire_rate) : APB_DW'(water_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      water_rate <= RATE_W'(1);
      fire_rate  <= RATE_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WATER: water_rate <= pwdata[RATE_W-1:0];
        REG_FIRE:  fire_rate  <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front stage: beat capture and cost classification
  ssms_front #(
    .MAX_TOTAL (MAX_TOTAL)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .stat   (stat),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // decoupling queue
  ssms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: bitset update, split scan and result register
  ssms_back #(
    .MAX_TOTAL (MAX_TOTAL)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .water_rate (water_rate),
    .fire_rate  (fire_rate),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .stat       (stat),
    .results    (results)
  );

endmodule

`default_nettype wire

@@ rtl/ssms_ram.sv @@
// generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module ssms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic      [WIDTH-1:0]                        rdata0,
  output logic      [WIDTH-1:0]                        rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

@@ rtl/ssms_front.sv @@
// front: takes item beats into a stage register and classifies them
// depends on ssms_pkg and ssms_if
`default_nettype none

module ssms_front
  import ssms_pkg::*;
#(
  parameter int MAX_TOTAL = 65535
) (
  input  wire logic       clk,
  input  wire logic       rst,
  ssms_item_if.sink       items,
  input  wire back_stat_t stat,
  input  wire logic       q_full,
  output logic            q_push,
  output task_t           q_data
);

  localparam int CMP_W = (($clog2(MAX_TOTAL + 1) > COST_W) ? $clog2(MAX_TOTAL + 1) : COST_W) + 1;

  logic  stg_valid;
  task_t stg;

  assign q_push      = stg_valid && !q_full;
  assign q_data      = stg;
  assign items.ready = !stat.clearing && (!stg_valid || q_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      stg_valid <= 1'b1;
    end else if (q_push) begin
      stg_valid <= 1'b0;
    end
  end

  // a zero cost or one above MAX_TOTAL leaves the bitset as it is
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      stg.cost     <= items.item_cost;
      stg.last     <= items.item_last;
      stg.shift_en <= (items.item_cost != '0) &&
                      (CMP_W'(items.item_cost) <= CMP_W'(MAX_TOTAL));
    end
  end

endmodule

`default_nettype wire

@@ rtl/ssms_queue.sv @@
// short fifo of classified items between front and back
// depends on ssms_pkg
`default_nettype none

module ssms_queue
  import ssms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire task_t push_data,
  output logic       full,
  input  wire logic  pop,
  output task_t      pop_data,
  output logic       empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  task_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop && !empty) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wp] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ssms_back.sv @@
// back: shift-or over the bitset memory, split scan and clearing sweep
// depends on ssms_pkg, ssms_if and ssms_ram
`default_nettype none

module ssms_back
  import ssms_pkg::*;
#(
  parameter int MAX_TOTAL = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [RATE_W-1:0] water_rate,
  input  wire logic [RATE_W-1:0] fire_rate,
  input  wire logic              q_empty,
  input  wire task_t             q_data,
  output logic                   q_pop,
  output back_stat_t             stat,
  ssms_result_if.source          results
);

  localparam int NWORDS   = MAX_TOTAL / WORD_W + 1;
  localparam int ADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int TOTAL_W  = $clog2(MAX_TOTAL + 1);
  localparam int SUM_W    = ((TOTAL_W > COST_W) ? TOTAL_W : COST_W) + 1;
  localparam int SAT_W    = (TOTAL_W > TIME_W) ? TOTAL_W : TIME_W;
  localparam int CNT_W    = $clog2(TOTAL_W + 1);
  localparam int TOP_BITS = MAX_TOTAL % WORD_W + 1;
  localparam logic [WORD_W-1:0] TOP_MASK = (TOP_BITS == WORD_W) ? {WORD_W{1'b1}} :
    WORD_W'(((WORD_W + 1)'(1) << TOP_BITS) - (WORD_W + 1)'(1));
  localparam logic [ADDR_W-1:0]  LAST_WORD = ADDR_W'(NWORDS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_TOTAL);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SH_RD0 = 9'b000000100,
    S_SH_RD1 = 9'b000001000,
    S_SH_WR  = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_SC_RD  = 9'b001000000,
    S_SC_EV  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t              state;
  logic [TOTAL_W-1:0]  total;
  logic                ovf;
  logic                last_pend;
  logic [WORD_SH-1:0]  cost_r;
  logic [ADDR_W-1:0]   qw;
  logic [ADDR_W-1:0]   w;
  logic [ADDR_W-1:0]   s;
  logic [WORD_W-1:0]   dw;
  logic [WORD_W-1:0]   ds;
  logic [ADDR_W-1:0]   clr_addr;
  logic [TOTAL_W-1:0]  i;
  logic [TOTAL_W-1:0]  j;
  logic [TOTAL_W-1:0]  qa;
  logic [TOTAL_W-1:0]  qb;
  logic [RATE_W-1:0]   ra;
  logic [RATE_W-1:0]   rb;
  logic [TOTAL_W-1:0]  best;
  logic [CNT_W-1:0]    div_cnt;
  logic                res_valid;
  logic [TIME_W-1:0]   res_time;
  logic                res_ovf;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_ra0;
  logic [ADDR_W-1:0]   ram_ra1;
  logic [WORD_W-1:0]   ram_rd0;
  logic [WORD_W-1:0]   ram_rd1;

  logic [RATE_W-1:0]   fr;
  logic [RATE_W-1:0]   wr;
  logic [SUM_W-1:0]    sum;
  logic [ADDR_W-1:0]   pop_q;
  logic [2*WORD_W-1:0] shifted;
  logic [WORD_W-1:0]   new_word;
  logic [RATE_W:0]     cand;
  logic                qbit;
  logic [TOTAL_W:0]    qb_shift;
  logic [TOTAL_W-1:0]  ca;
  logic [TOTAL_W-1:0]  cb;
  logic [TOTAL_W-1:0]  tcur;
  logic                hit;
  logic [SAT_W-1:0]    bsat;

  // a zero rate counts as one
  assign fr = (fire_rate == '0) ? RATE_W'(1) : fire_rate;
  assign wr = (water_rate == '0) ? RATE_W'(1) : water_rate;

  assign q_pop         = (state == S_IDLE) && !q_empty;
  assign stat.clearing = (state == S_CLEAR);

  assign results.valid    = res_valid;
  assign results.min_time = res_time;
  assign results.overflow = res_ovf;

  assign sum   = SUM_W'(total) + SUM_W'(q_data.cost);
  assign pop_q = ADDR_W'(q_data.cost >> WORD_SH);

  // word w takes source word s and the top of word s-1
  assign shifted  = {ds, ((s == '0) ? {WORD_W{1'b0}} : ram_rd1)} << cost_r;
  assign new_word = (dw | shifted[2*WORD_W-1:WORD_W]) &
                    ((w == LAST_WORD) ? TOP_MASK : {WORD_W{1'b1}});

  // restoring divider step for total / water rate
  assign cand     = {rb, qb[TOTAL_W-1]};
  assign qbit     = (cand >= {1'b0, wr});
  assign qb_shift = {qb, qbit};

  assign ca   = qa + TOTAL_W'(ra != '0);
  assign cb   = qb + TOTAL_W'(rb != '0);
  assign tcur = (ca > cb) ? ca : cb;
  assign hit  = ram_rd0[WORD_SH'(i)] && ram_rd1[WORD_SH'(j)];
  assign bsat = SAT_W'(best);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = {{(WORD_W-1){1'b0}}, (clr_addr == '0)};
    ram_ra0   = w;
    ram_ra1   = s;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SH_RD1: begin
        ram_ra1 = (s == '0) ? '0 : s - ADDR_W'(1);
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = w;
        ram_wdata = new_word;
      end
      S_SC_RD: begin
        ram_ra0 = ADDR_W'(i >> WORD_SH);
        ram_ra1 = ADDR_W'(j >> WORD_SH);
      end
      default: begin
      end
    endcase
  end

  ssms_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_bits (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_ra0),
    .raddr1 (ram_ra1),
    .rdata0 (ram_rd0),
    .rdata1 (ram_rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      total     <= '0;
      ovf       <= 1'b0;
      last_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            if (sum > SUM_W'(MAX_TOTAL)) begin
              total <= TOTAL_MAX;
              ovf   <= 1'b1;
            end else begin
              total <= sum[TOTAL_W-1:0];
            end
            last_pend <= q_data.last;
            cost_r    <= q_data.cost[WORD_SH-1:0];
            qw        <= pop_q;
            w         <= LAST_WORD;
            s         <= LAST_WORD - pop_q;
            if (q_data.shift_en) begin
              state <= S_SH_RD0;
            end else if (q_data.last) begin
              state <= S_DIV;
            end
            div_cnt <= '0;
            rb      <= '0;
            qb      <= (sum > SUM_W'(MAX_TOTAL)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
          end
        end
        S_SH_RD0: begin
          state <= S_SH_RD1;
        end
        S_SH_RD1: begin
          dw    <= ram_rd0;
          ds    <= ram_rd1;
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          if (w == qw) begin
            div_cnt <= '0;
            rb      <= '0;
            qb      <= total;
            state   <= last_pend ? S_DIV : S_IDLE;
          end else begin
            w     <= w - ADDR_W'(1);
            s     <= s - ADDR_W'(1);
            state <= S_SH_RD0;
          end
        end
        S_DIV: begin
          rb      <= qbit ? RATE_W'(cand - {1'b0, wr}) : cand[RATE_W-1:0];
          qb      <= qb_shift[TOTAL_W-1:0];
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(TOTAL_W - 1)) begin
            i     <= '0;
            j     <= total;
            qa    <= '0;
            ra    <= '0;
            best  <= total;
            state <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          state <= S_SC_EV;
        end
        S_SC_EV: begin
          if (hit && (tcur < best)) begin
            best <= tcur;
          end
          if (i == total) begin
            state <= S_OUT;
          end else begin
            i <= i + TOTAL_W'(1);
            j <= j - TOTAL_W'(1);
            if (({1'b0, ra} + (RATE_W + 1)'(1)) == {1'b0, fr}) begin
              ra <= '0;
              qa <= qa + TOTAL_W'(1);
            end else begin
              ra <= ra + RATE_W'(1);
            end
            if (rb == '0) begin
              rb <= wr - RATE_W'(1);
              qb <= qb - TOTAL_W'(1);
            end else begin
              rb <= rb - RATE_W'(1);
            end
            state <= S_SC_RD;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            res_time  <= (bsat > SAT_W'({TIME_W{1'b1}})) ? {TIME_W{1'b1}} :
                         bsat[TIME_W-1:0];
            res_ovf   <= ovf;
            total     <= '0;
            ovf       <= 1'b0;
            last_pend <= 1'b0;
            clr_addr  <= '0;
            state     <= S_CLEAR;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE))
    else $error("queue popped outside idle");

  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || (state == S_SH_WR)))
    else $error("bitset written outside clear or shift");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_EV) |-> ((i <= total) && ((i + j) == total)))
    else $error("split index out of step with total");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && res_valid && !results.ready) |=> (state == S_OUT))
    else $error("result overwritten while waiting");
`endif

endmodule

`default_nettype wire
